>>> design/range_add_range_max_tree_unit_defines.svh
// Assertion macros for the range add / range max tree unit.
// Both expect clk and arst_n in the scope of the use.
`ifndef RANGE_ADD_RANGE_MAX_TREE_UNIT_DEFINES_SVH
`define RANGE_ADD_RANGE_MAX_TREE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define RARM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RARM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RARM_ASSERT_NOW(lbl, ante, cons, msg)
`define RARM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/rarm_pkg.sv
package rarm_pkg;

	localparam int LEAVES_DEF      = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [1:0] FUNC_ADD  = 2'd0;
	localparam logic [1:0] FUNC_MAX  = 2'd1;
	localparam logic [1:0] FUNC_FILL = 2'd2;
	localparam logic [1:0] FUNC_NOP  = 2'd3;

	localparam int OPW = 5;
	localparam logic [OPW-1:0] OP_NOP      = 5'd0;
	localparam logic [OPW-1:0] OP_LOAD     = 5'd1;
	localparam logic [OPW-1:0] OP_RD_L     = 5'd2;
	localparam logic [OPW-1:0] OP_WR_L     = 5'd3;
	localparam logic [OPW-1:0] OP_RD_R     = 5'd4;
	localparam logic [OPW-1:0] OP_WR_R     = 5'd5;
	localparam logic [OPW-1:0] OP_SHIFT_LR = 5'd6;
	localparam logic [OPW-1:0] OP_TA       = 5'd7;
	localparam logic [OPW-1:0] OP_TB       = 5'd8;
	localparam logic [OPW-1:0] OP_RD_C1    = 5'd9;
	localparam logic [OPW-1:0] OP_RD_T     = 5'd10;
	localparam logic [OPW-1:0] OP_W_C0     = 5'd11;
	localparam logic [OPW-1:0] OP_W_C1     = 5'd12;
	localparam logic [OPW-1:0] OP_W_T      = 5'd13;
	localparam logic [OPW-1:0] OP_SHIFT_AB = 5'd14;
	localparam logic [OPW-1:0] OP_QL       = 5'd15;
	localparam logic [OPW-1:0] OP_QR       = 5'd16;
	localparam logic [OPW-1:0] OP_P_RD     = 5'd17;
	localparam logic [OPW-1:0] OP_P_AC     = 5'd18;
	localparam logic [OPW-1:0] OP_BEST     = 5'd19;
	localparam logic [OPW-1:0] OP_EMIT     = 5'd20;
	localparam logic [OPW-1:0] OP_CLR_Z    = 5'd21;
	localparam logic [OPW-1:0] OP_CLR_F    = 5'd22;

	typedef struct packed {
		logic [1:0]         func;
		logic [9:0]         lo;
		logic [10:0]        hi;
		logic signed [31:0] amount;
	} in_t;

	typedef struct packed {
		logic signed [31:0] max_value;
		logic               valid_res;
	} out_t;

	typedef struct packed {
		logic [OPW-1:0] op;
	} cmd_t;

	typedef struct packed {
		logic lt;
		logic l_odd;
		logic r_odd;
		logic a_zero;
		logic ab_ne;
		logic walk_nz;
		logic clr_last;
		logic empty;
		logic out_blocked;
	} stat_t;

endpackage

>>> design/rarm_ctrl.sv
module rarm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     func,
	input  rarm_pkg::stat_t stat,
	output logic           in_stall,
	output rarm_pkg::cmd_t cmd
);
	import rarm_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_CLR   = 5'd1;
	localparam logic [4:0] S_ADD0  = 5'd2;
	localparam logic [4:0] S_A_T   = 5'd3;
	localparam logic [4:0] S_A_LW  = 5'd4;
	localparam logic [4:0] S_A_RC  = 5'd5;
	localparam logic [4:0] S_A_RW  = 5'd6;
	localparam logic [4:0] S_SET_T = 5'd7;
	localparam logic [4:0] S_T1    = 5'd8;
	localparam logic [4:0] S_T2    = 5'd9;
	localparam logic [4:0] S_T3    = 5'd10;
	localparam logic [4:0] S_T4    = 5'd11;
	localparam logic [4:0] S_T5    = 5'd12;
	localparam logic [4:0] S_AFT   = 5'd13;
	localparam logic [4:0] S_Q0    = 5'd14;
	localparam logic [4:0] S_Q_T   = 5'd15;
	localparam logic [4:0] S_Q_RC  = 5'd16;
	localparam logic [4:0] S_P_R   = 5'd17;
	localparam logic [4:0] S_P_A   = 5'd18;
	localparam logic [4:0] S_P_B   = 5'd19;
	localparam logic [4:0] S_Q_SH  = 5'd20;
	localparam logic [4:0] S_OUT   = 5'd21;

	logic [4:0] state_q, state_d;
	logic       fill_q, fill_d;
	logic       side_b_q, side_b_d;
	logic       side_r_q, side_r_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		side_b_d = side_b_q;
		side_r_d = side_r_q;
		cmd.op   = OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					unique case (func)
						FUNC_ADD:  state_d = S_ADD0;
						FUNC_MAX:  state_d = S_Q0;
						FUNC_FILL: begin
							state_d = S_CLR;
							fill_d  = 1'b1;
						end
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_CLR: begin
				cmd.op = fill_q ? OP_CLR_F : OP_CLR_Z;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_ADD0: state_d = stat.empty ? S_IDLE : S_A_T;
			S_A_T: begin
				if (!stat.lt) begin
					state_d = S_SET_T;
				end else if (stat.l_odd) begin
					cmd.op  = OP_RD_L;
					state_d = S_A_LW;
				end else begin
					state_d = S_A_RC;
				end
			end
			S_A_LW: begin
				cmd.op  = OP_WR_L;
				state_d = S_A_RC;
			end
			S_A_RC: begin
				if (stat.r_odd) begin
					cmd.op  = OP_RD_R;
					state_d = S_A_RW;
				end else begin
					cmd.op  = OP_SHIFT_LR;
					state_d = S_A_T;
				end
			end
			S_A_RW: begin
				cmd.op  = OP_WR_R;
				state_d = S_A_T;
			end
			S_SET_T: begin
				if (stat.a_zero) begin
					state_d = S_IDLE;
				end else begin
					cmd.op   = OP_TA;
					side_b_d = 1'b0;
					state_d  = S_T1;
				end
			end
			S_T1: begin
				cmd.op  = OP_RD_C1;
				state_d = S_T2;
			end
			S_T2: begin
				cmd.op  = OP_RD_T;
				state_d = S_T3;
			end
			S_T3: begin
				cmd.op  = OP_W_C0;
				state_d = S_T4;
			end
			S_T4: begin
				cmd.op  = OP_W_C1;
				state_d = S_T5;
			end
			S_T5: begin
				cmd.op  = OP_W_T;
				state_d = S_AFT;
			end
			S_AFT: begin
				// settle the right boundary node unless both paths have merged
				if (!side_b_q && stat.ab_ne) begin
					cmd.op   = OP_TB;
					side_b_d = 1'b1;
					state_d  = S_T1;
				end else begin
					cmd.op  = OP_SHIFT_AB;
					state_d = S_SET_T;
				end
			end
			S_Q0: state_d = stat.empty ? S_OUT : S_Q_T;
			S_Q_T: begin
				if (!stat.lt) begin
					state_d = S_OUT;
				end else if (stat.l_odd) begin
					cmd.op   = OP_QL;
					side_r_d = 1'b0;
					state_d  = S_P_R;
				end else begin
					state_d = S_Q_RC;
				end
			end
			S_Q_RC: begin
				if (stat.r_odd) begin
					cmd.op   = OP_QR;
					side_r_d = 1'b1;
					state_d  = S_P_R;
				end else begin
					cmd.op  = OP_SHIFT_LR;
					state_d = S_Q_T;
				end
			end
			S_P_R: begin
				cmd.op  = OP_P_RD;
				state_d = S_P_A;
			end
			S_P_A: begin
				cmd.op  = OP_P_AC;
				state_d = stat.walk_nz ? S_P_R : S_P_B;
			end
			S_P_B: begin
				cmd.op  = OP_BEST;
				state_d = side_r_q ? S_Q_SH : S_Q_RC;
			end
			S_Q_SH: begin
				cmd.op  = OP_SHIFT_LR;
				state_d = S_Q_T;
			end
			S_OUT: begin
				if (!stat.out_blocked) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			fill_q   <= 1'b0;
			side_b_q <= 1'b0;
			side_r_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= (state_q == S_CLR && stat.clr_last) ? 1'b0 : fill_d;
			side_b_q <= side_b_d;
			side_r_q <= side_r_d;
		end
	end

endmodule

>>> design/rarm_dp.sv
module rarm_dp #(
	parameter int LEAVES      = rarm_pkg::LEAVES_DEF,
	parameter int VALUE_WIDTH = rarm_pkg::VALUE_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rarm_pkg::in_t   in_data,
	input  rarm_pkg::cmd_t  cmd,
	input  logic            out_stall,
	output logic            out_valid,
	output rarm_pkg::out_t  out_data,
	output rarm_pkg::stat_t stat
);
	import rarm_pkg::*;

	localparam int LW    = $clog2(LEAVES);
	localparam int NW    = LW + 1;
	localparam int IW    = NW + 1;
	localparam int DEPTH = 2 * LEAVES;
	localparam int CW    = (IW > 11) ? IW : 11;
	localparam int VW    = VALUE_WIDTH;

	logic [VW-1:0] mem [DEPTH];
	logic [VW-1:0] rdata_q;

	logic [IW-1:0] l_q, r_q;
	logic [LW-1:0] a_q, b_q, t_q;
	logic [NW-1:0] walk_q, clr_q;
	logic [VW-1:0] amt_q, acc_q, best_q, c0_q, c1_q, m_q, pt_q;
	logic          any_q, empty_q, out_valid_q;
	out_t          out_q;

	logic [CW-1:0] lo_c, hi_c, hs_c;
	logic [IW-1:0] l_init, r_init, b_sum, r_m1;
	logic [63:0]   amt_ext, best_ext;
	logic          rd_en, wr_en;
	logic [NW-1:0] ra, wa;
	logic [VW-1:0] wd;

	assign lo_c    = CW'(in_data.lo);
	assign hi_c    = CW'(in_data.hi);
	assign hs_c    = (hi_c > CW'(LEAVES)) ? CW'(LEAVES) : hi_c;
	assign l_init  = IW'(lo_c) + IW'(LEAVES);
	assign r_init  = IW'(hs_c) + IW'(LEAVES);
	assign b_sum   = r_init - IW'(1);
	assign r_m1    = r_q - IW'(1);
	assign amt_ext = 64'(in_data.amount);
	assign best_ext = 64'(signed'(best_q));

	always_comb begin
		rd_en = 1'b0;
		wr_en = 1'b0;
		ra    = '0;
		wa    = '0;
		wd    = '0;
		unique case (cmd.op)
			OP_RD_L: begin
				rd_en = 1'b1;
				ra    = l_q[NW-1:0];
			end
			OP_RD_R: begin
				rd_en = 1'b1;
				ra    = r_m1[NW-1:0];
			end
			OP_TA: begin
				rd_en = 1'b1;
				ra    = {a_q, 1'b0};
			end
			OP_TB: begin
				rd_en = 1'b1;
				ra    = {b_q, 1'b0};
			end
			OP_RD_C1: begin
				rd_en = 1'b1;
				ra    = {t_q, 1'b1};
			end
			OP_RD_T: begin
				rd_en = 1'b1;
				ra    = {1'b0, t_q};
			end
			OP_P_RD: begin
				rd_en = 1'b1;
				ra    = walk_q;
			end
			OP_WR_L: begin
				wr_en = 1'b1;
				wa    = l_q[NW-1:0];
				wd    = rdata_q + amt_q;
			end
			OP_WR_R: begin
				wr_en = 1'b1;
				wa    = r_q[NW-1:0];
				wd    = rdata_q + amt_q;
			end
			OP_W_C0: begin
				wr_en = 1'b1;
				wa    = {t_q, 1'b0};
				wd    = c0_q - m_q;
			end
			OP_W_C1: begin
				wr_en = 1'b1;
				wa    = {t_q, 1'b1};
				wd    = c1_q - m_q;
			end
			OP_W_T: begin
				wr_en = 1'b1;
				wa    = {1'b0, t_q};
				wd    = pt_q + m_q;
			end
			OP_CLR_Z: begin
				wr_en = 1'b1;
				wa    = clr_q;
			end
			OP_CLR_F: begin
				// the root takes the fill value, everything else clears
				wr_en = 1'b1;
				wa    = clr_q;
				wd    = (clr_q == NW'(1)) ? amt_q : '0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rdata_q <= mem[ra];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				amt_q  <= amt_ext[VW-1:0];
				l_q    <= l_init;
				r_q    <= r_init;
				a_q    <= l_init[NW-1:1];
				b_q    <= b_sum[NW-1:1];
				best_q <= '0;
				any_q  <= 1'b0;
				empty_q <= (lo_c >= hs_c);
			end
			OP_WR_L: l_q <= l_q + IW'(1);
			OP_RD_R: r_q <= r_m1;
			OP_WR_R: begin
				l_q <= l_q >> 1;
				r_q <= r_q >> 1;
			end
			OP_SHIFT_LR: begin
				l_q <= l_q >> 1;
				r_q <= r_q >> 1;
			end
			OP_TA: t_q <= a_q;
			OP_TB: t_q <= b_q;
			OP_RD_C1: c0_q <= rdata_q;
			OP_RD_T: begin
				c1_q <= rdata_q;
				m_q  <= ($signed(c0_q) >= $signed(rdata_q)) ? c0_q : rdata_q;
			end
			OP_W_C0: pt_q <= rdata_q;
			OP_SHIFT_AB: begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
			end
			OP_QL: begin
				walk_q <= l_q[NW-1:0];
				acc_q  <= '0;
				l_q    <= l_q + IW'(1);
			end
			OP_QR: begin
				walk_q <= r_m1[NW-1:0];
				acc_q  <= '0;
				r_q    <= r_m1;
			end
			OP_P_RD: walk_q <= walk_q >> 1;
			OP_P_AC: acc_q <= acc_q + rdata_q;
			OP_BEST: begin
				if (!any_q || $signed(acc_q) > $signed(best_q)) begin
					best_q <= acc_q;
				end
				any_q <= 1'b1;
			end
			OP_EMIT: begin
				out_q.max_value <= best_ext[31:0];
				out_q.valid_res <= any_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_CLR_Z || cmd.op == OP_CLR_F) begin
				clr_q <= clr_q + NW'(1);
			end
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign out_data         = out_q;
	assign stat.lt          = (l_q < r_q);
	assign stat.l_odd       = l_q[0];
	assign stat.r_odd       = r_q[0];
	assign stat.a_zero      = (a_q == '0);
	assign stat.ab_ne       = (a_q != b_q);
	assign stat.walk_nz     = (walk_q != '0);
	assign stat.clr_last    = (clr_q == '1);
	assign stat.empty       = empty_q;
	assign stat.out_blocked = out_valid_q && out_stall;

endmodule

>>> design/range_add_range_max_tree_unit.sv
// Channel  Handshake             Word
// in       in_valid / in_stall   in_data  : func, lo, hi, amount
// out      out_valid / out_stall out_data : max_value, valid_res
//
// One request at a time; in_stall is low only while the sequencer is idle.
// Add: a boundary walk over the levels, then the left node and, while the two
// paths differ, the right node of each level are settled; a query walks from
// each covering node to the root, paced by the single read port of the node memory.
// Fill and reset each run a clearing pass over all 2*LEAVES words of the memory.
// A query result waits in the output register while out_stall is high.
`include "range_add_range_max_tree_unit_defines.svh"

module range_add_range_max_tree_unit #(
	parameter int LEAVES      = rarm_pkg::LEAVES_DEF,
	parameter int VALUE_WIDTH = rarm_pkg::VALUE_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  rarm_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output rarm_pkg::out_t out_data
);
	import rarm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	rarm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (in_data.func),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	rarm_dp #(
		.LEAVES      (LEAVES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.stat      (stat)
	);

	`RARM_ASSERT_NOW(a_empty_zero, out_valid && !out_data.valid_res, out_data.max_value == 32'sd0, "empty max")
	`RARM_ASSERT_NEXT(a_busy, in_valid && !in_stall && in_data.func != FUNC_NOP, in_stall, "not busy")

endmodule

>>> tb/sv/tb_range_add_range_max_tree_unit.sv
module tb_range_add_range_max_tree_unit;
	import rarm_pkg::*;

	localparam int NLEAF = LEAVES_DEF;
	localparam int NNODE = 2 * NLEAF;
	localparam int IDLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	range_add_range_max_tree_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [31:0] delta [NNODE] = '{default: '0};
	out_t max_q [$];
	int errors = 0;
	int idle_cycles = 0;
	bit stim_done = 0;
	bit hold_off = 0;

	function automatic logic [31:0] smax(logic [31:0] a, logic [31:0] b);
		return ($signed(a) >= $signed(b)) ? a : b;
	endfunction

	function automatic logic [31:0] path_sum(int v);
		logic [31:0] s;
		s = '0;
		while (v >= 1) begin
			s += delta[v];
			v >>= 1;
		end
		return s;
	endfunction

	task automatic settle_node(int i);
		logic [31:0] m;
		if (2 * i + 1 >= NNODE) return;
		m = smax(delta[2*i], delta[2*i+1]);
		delta[2*i] -= m;
		delta[2*i+1] -= m;
		delta[i] += m;
	endtask

	// Update the tree model with one word; queue the expected result for a query.
	task automatic tree_apply(in_t w);
		int lo, hi, l, r, a, b;
		logic [31:0] best, amt, v;
		bit any;
		out_t res;
		lo = w.lo;
		hi = (w.hi > NLEAF) ? NLEAF : w.hi;
		amt = w.amount;
		case (w.func)
			FUNC_FILL: begin
				foreach (delta[k]) delta[k] = '0;
				delta[1] = amt;
			end
			FUNC_ADD: begin
				if (lo < hi) begin
					l = lo + NLEAF;
					r = hi + NLEAF;
					while (l < r) begin
						if (l & 1) begin
							delta[l] += amt;
							l++;
						end
						if (r & 1) begin
							r--;
							delta[r] += amt;
						end
						l >>= 1;
						r >>= 1;
					end
					a = (lo + NLEAF) >> 1;
					b = (hi - 1 + NLEAF) >> 1;
					while (a >= 1) begin
						settle_node(a);
						if (b != a) settle_node(b);
						a >>= 1;
						b >>= 1;
					end
				end
			end
			FUNC_MAX: begin
				any = 0;
				best = '0;
				if (lo < hi) begin
					l = lo + NLEAF;
					r = hi + NLEAF;
					while (l < r) begin
						if (l & 1) begin
							v = path_sum(l);
							best = any ? smax(best, v) : v;
							any = 1;
							l++;
						end
						if (r & 1) begin
							r--;
							v = path_sum(r);
							best = any ? smax(best, v) : v;
							any = 1;
						end
						l >>= 1;
						r >>= 1;
					end
				end
				res.max_value = any ? best : '0;
				res.valid_res = any;
				max_q = {max_q, res};
			end
			default: ;
		endcase
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
		errors++;
	endtask

	// Offer one word and hold it until accepted.
	task automatic send_word(in_t w);
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tree_apply(w);
	endtask

	task automatic pause_sender();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 12)) @(posedge clk);
	endtask

	function automatic in_t rand_word();
		in_t w;
		int p, span;
		p = $urandom_range(0, 99);
		w.func = (p < 45) ? FUNC_ADD : (p < 93) ? FUNC_MAX : (p < 97) ? FUNC_FILL : FUNC_NOP;
		w.lo = $urandom_range(0, NLEAF - 1);
		span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NLEAF) : $urandom_range(0, 24);
		w.hi = ($urandom_range(0, 19) == 0) ? 11'($urandom) : 11'(w.lo + span);
		case ($urandom_range(0, 3))
			0: w.amount = $urandom;
			1: w.amount = $signed(32'($urandom_range(0, 2000))) - 1000;
			default: w.amount = $signed(32'($urandom_range(0, 200))) - 100;
		endcase
		return w;
	endfunction

	typedef struct {
		in_t w;
		bit chk;
		out_t want;
	} row_t;

	row_t rows [] = '{
		'{'{FUNC_MAX, 10'd0, 11'd1024, 32'sd0}, 1, '{32'sd0, 1'b1}},
		'{'{FUNC_MAX, 10'd5, 11'd5, 32'sd0}, 1, '{32'sd0, 1'b0}},
		'{'{FUNC_MAX, 10'd1023, 11'd3, 32'sd0}, 1, '{32'sd0, 1'b0}},
		'{'{FUNC_ADD, 10'd7, 11'd3, 32'sd99}, 0, '0},
		'{'{FUNC_MAX, 10'd0, 11'd2047, 32'sd0}, 1, '{32'sd0, 1'b1}},
		'{'{FUNC_FILL, 10'd0, 11'd0, 32'h7fffffff}, 0, '0},
		'{'{FUNC_MAX, 10'd1023, 11'd1024, 32'sd0}, 1, '{32'h7fffffff, 1'b1}},
		'{'{FUNC_ADD, 10'd0, 11'd1, 32'sd1}, 0, '0},
		'{'{FUNC_MAX, 10'd0, 11'd1024, 32'sd0}, 0, '0},
		'{'{FUNC_FILL, 10'd0, 11'd0, 32'h80000000}, 0, '0},
		'{'{FUNC_MAX, 10'd300, 11'd301, 32'sd0}, 1, '{32'h80000000, 1'b1}},
		'{'{FUNC_ADD, 10'd3, 11'd1800, 32'sd5}, 0, '0},
		'{'{FUNC_ADD, 10'd1023, 11'd1024, 32'h7fffffff}, 0, '0},
		'{'{FUNC_MAX, 10'd0, 11'd3, 32'sd0}, 0, '0},
		'{'{FUNC_MAX, 10'd1000, 11'd1024, 32'sd0}, 0, '0},
		'{'{FUNC_NOP, 10'h3ff, 11'h7ff, 32'hffffffff}, 0, '0},
		'{'{FUNC_ADD, 10'd100, 11'd611, 32'hffffffff}, 0, '0},
		'{'{FUNC_MAX, 10'd90, 11'd700, 32'sd0}, 0, '0},
		'{'{FUNC_MAX, 10'd512, 11'd513, 32'sd0}, 0, '0},
		'{'{FUNC_FILL, 10'd0, 11'd0, 32'sd0}, 0, '0},
		'{'{FUNC_MAX, 10'd0, 11'd1024, 32'sd0}, 1, '{32'sd0, 1'b1}}
	};

	initial begin
		in_t w;
		int n_sent;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].chk) begin
				tree_apply(rows[i].w);
				max_q[max_q.size() - 1] = rows[i].want;
				// feed the row without re-predicting
				in_valid <= 1'b1;
				in_data <= rows[i].w;
				@(posedge clk);
				while (in_stall) @(posedge clk);
			end else begin
				send_word(rows[i].w);
			end
			if ($urandom_range(0, 2) == 0) pause_sender();
		end
		n_sent = 0;
		while (n_sent < 650) begin
			repeat ($urandom_range(1, 20)) begin
				w = rand_word();
				send_word(w);
				n_sent++;
			end
			if ($urandom_range(0, 3) != 0) pause_sender();
		end
		in_valid <= 1'b0;
		stim_done = 1;
	end

	// Receiver: random stall pattern, plus one long hold-off mid-run.
	initial begin
		int cyc;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 6000) begin
				hold_off = 1;
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				hold_off = 0;
			end else if ((cyc / 500) % 3 == 0) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (max_q.size() == 0) begin
				report("unexpected word", out_data.max_value, 32'd0);
			end else begin
				want = max_q.pop_front();
				if (out_data.valid_res !== want.valid_res)
					report("valid_res", 32'(out_data.valid_res), 32'(want.valid_res));
				if (out_data.max_value !== want.max_value)
					report("max_value", out_data.max_value, want.max_value);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
			if (stim_done && max_q.size() == 0) begin
				repeat (4 * NNODE) @(posedge clk);
				if (errors == 0)
					$display("TEST PASSED");
				else
					$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule
